// ===== src/srts_pkg.sv =====
// Shared widths, codes and word types of the shortest-remaining-time scheduler.
package srts_pkg;

	localparam int MAX_PROCS_DEF = 16;

	localparam int BURST_W = 12;
	localparam int ARR_W   = 16;
	localparam int TIME_W  = 17;
	localparam int SUM_W   = 21;
	localparam int IDX_W   = 4;

	localparam logic EV_DISPATCH = 1'b0;
	localparam logic EV_COMPLETE = 1'b1;

	// One stored process: burst, arrival and remaining time.
	typedef struct packed {
		logic [BURST_W-1:0] burst;
		logic [ARR_W-1:0]   arrival;
		logic [BURST_W-1:0] remaining;
	} proc_entry_t;

	// One result word as it leaves the block.
	typedef struct packed {
		logic              event_kind;
		logic [IDX_W-1:0]  process_index;
		logic [TIME_W-1:0] event_time;
		logic [TIME_W-1:0] turnaround;
		logic [TIME_W-1:0] waiting;
		logic [SUM_W-1:0]  total_waiting;
		logic [SUM_W-1:0]  total_turnaround;
		logic              last_result;
	} result_t;

endpackage

// ===== src/srts_ifs.sv =====
// Valid/ready channel interfaces for process words in and result words out.
interface srts_in_if;
	logic                         valid;
	logic                         ready;
	logic [srts_pkg::BURST_W-1:0] burst_len;
	logic [srts_pkg::ARR_W-1:0]   arrive_at;
	logic                         last_process;

	modport source (output valid, output burst_len, output arrive_at,
		output last_process, input ready);
	modport sink (input valid, input burst_len, input arrive_at,
		input last_process, output ready);
endinterface

interface srts_out_if;
	logic                        valid;
	logic                        ready;
	logic                        event_kind;
	logic [srts_pkg::IDX_W-1:0]  process_index;
	logic [srts_pkg::TIME_W-1:0] event_time;
	logic [srts_pkg::TIME_W-1:0] turnaround;
	logic [srts_pkg::TIME_W-1:0] waiting;
	logic [srts_pkg::SUM_W-1:0]  total_waiting;
	logic [srts_pkg::SUM_W-1:0]  total_turnaround;
	logic                        last_result;

	modport source (output valid, output event_kind, output process_index,
		output event_time, output turnaround, output waiting, output total_waiting,
		output total_turnaround, output last_result, input ready);
	modport sink (input valid, input event_kind, input process_index,
		input event_time, input turnaround, input waiting, input total_waiting,
		input total_turnaround, input last_result, output ready);
endinterface

// ===== src/srts_out_reg.sv =====
// Output holding register that drives the result channel.
module srts_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  srts_pkg::result_t word,
	output logic              free,
	srts_out_if.source        report
);

	logic              valid_q;
	srts_pkg::result_t word_q;

	// The register can take a new word when empty or when its word leaves now.
	assign free = !valid_q || report.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (report.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			word_q <= word;
		end
	end

	assign report.valid            = valid_q;
	assign report.event_kind       = word_q.event_kind;
	assign report.process_index    = word_q.process_index;
	assign report.event_time       = word_q.event_time;
	assign report.turnaround       = word_q.turnaround;
	assign report.waiting          = word_q.waiting;
	assign report.total_waiting    = word_q.total_waiting;
	assign report.total_turnaround = word_q.total_turnaround;
	assign report.last_result      = word_q.last_result;

endmodule

// ===== src/shortest_remaining_time_scheduler_unit.sv =====
// Top level of the preemptive shortest-remaining-time-first scheduler.
//
// Usage: processes are loaded on the load channel, one word per process, in
// load order. Each loading word gives no result. The word
// flagged last_process closes the set and starts the schedule; load.ready then
// stays low until the final completion word has been handed to the output
// register. Results leave on the report channel: a dispatch word whenever the
// running process changes and a completion word when a process finishes, the
// last one flagged last_result and carrying the final totals.
// The process table lives in one synchronous memory. Every scheduling decision
// is a scan through the table, one entry a cycle, through a registered read. A
// decision either runs the chosen process up to its completion or to the next
// arrival, or jumps idle time straight to the next arrival, so a schedule of N
// loaded processes needs at most about 2N decisions, independent of the burst
// lengths. A stalled receiver holds the report channel; the scheduler waits
// with the next word ready and loses nothing. Reset empties the process set and
// the output register; table contents are left as they are and are rewritten
// on loading. After the last completion the block returns to loading, empty.
module shortest_remaining_time_scheduler_unit #(
	parameter int MAX_PROCS = srts_pkg::MAX_PROCS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	srts_in_if.sink   load,
	srts_out_if.source report
);

	localparam int CNT_W  = $clog2(MAX_PROCS + 1);
	localparam int ADDR_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
	localparam int BW     = srts_pkg::BURST_W;
	localparam int AW     = srts_pkg::ARR_W;
	localparam int TW     = srts_pkg::TIME_W;
	localparam int SW     = srts_pkg::SUM_W;

	localparam logic [3:0] ST_LOAD   = 4'd0;
	localparam logic [3:0] ST_SCAN   = 4'd1;
	localparam logic [3:0] ST_DECIDE = 4'd2;
	localparam logic [3:0] ST_DISP   = 4'd3;
	localparam logic [3:0] ST_RUN    = 4'd4;
	localparam logic [3:0] ST_TAT    = 4'd5;
	localparam logic [3:0] ST_SUMS   = 4'd6;
	localparam logic [3:0] ST_EMITC  = 4'd7;

	// Process table: one entry per loaded process.
	srts_pkg::proc_entry_t mem [MAX_PROCS];
	srts_pkg::proc_entry_t mem_rd_s1;
	logic                  mem_we;
	logic [ADDR_W-1:0]     mem_wa;
	srts_pkg::proc_entry_t mem_wd;
	logic                  rd_en;

	logic [3:0]       state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] done_q;
	logic [TW-1:0]    sim_time_q;
	logic             run_vld_q;
	logic [ADDR_W-1:0] run_idx_q;
	logic [SW-1:0]    sum_w_q;
	logic [SW-1:0]    sum_t_q;

	// Scan pipeline and its running minimum.
	logic [CNT_W-1:0]  ptr_q;
	logic              rd_vld_s1;
	logic              rd_last_s1;
	logic [ADDR_W-1:0] rd_idx_s1;
	logic              found_q;
	logic [ADDR_W-1:0] best_idx_q;
	logic [BW-1:0]     best_rem_q;
	logic [AW-1:0]     best_arr_q;
	logic [BW-1:0]     best_burst_q;
	logic              nxt_found_q;
	logic [AW-1:0]     nxt_arr_q;

	logic [BW-1:0] len_q;
	logic [TW-1:0] tat_q;
	logic [TW-1:0] wt_q;

	logic              out_push;
	logic              out_free;
	srts_pkg::result_t out_word;

	logic          is_ready;
	logic          is_better;
	logic          is_future;
	logic [TW-1:0] rd_arr_ext;
	logic [TW-1:0] gap;
	logic          changed;
	logic [BW-1:0] rem_left;
	logic [BW-1:0] burst_in;
	logic [4:0]    best_idx_ext;

	assign load.ready = (state_q == ST_LOAD);

	// A zero burst is taken as one time unit.
	assign burst_in = (load.burst_len == '0) ? BW'(1) : load.burst_len;

	assign rd_en = (state_q == ST_SCAN) && (ptr_q < count_q);

	// Entry under evaluation: ready now, or arriving later.
	assign rd_arr_ext = TW'(mem_rd_s1.arrival);
	assign is_ready   = (mem_rd_s1.remaining != '0) && (rd_arr_ext <= sim_time_q);
	assign is_future  = (mem_rd_s1.remaining != '0) && (rd_arr_ext > sim_time_q);
	assign is_better  = !found_q || (mem_rd_s1.remaining < best_rem_q) ||
		((mem_rd_s1.remaining == best_rem_q) && (mem_rd_s1.arrival < best_arr_q));

	// Time until the next arrival; the chosen process runs at most that long.
	assign gap = TW'(nxt_arr_q) - sim_time_q;

	assign changed  = !run_vld_q || (run_idx_q != best_idx_q);
	assign rem_left = best_rem_q - len_q;
	assign best_idx_ext = 5'(best_idx_q);

	// Table writes come from loading and from the run update; the state
	// sequence keeps them apart from the scan reads.
	always_comb begin
		mem_we = 1'b0;
		mem_wa = count_q[ADDR_W-1:0];
		mem_wd = '{burst: burst_in, arrival: load.arrive_at, remaining: burst_in};
		if (state_q == ST_LOAD) begin
			mem_we = load.valid && (count_q < CNT_W'(MAX_PROCS));
		end else if (state_q == ST_RUN) begin
			mem_we = 1'b1;
			mem_wa = best_idx_q;
			mem_wd = '{burst: best_burst_q, arrival: best_arr_q, remaining: rem_left};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (rd_en) begin
			mem_rd_s1 <= mem[ptr_q[ADDR_W-1:0]];
		end
	end

	// Result word assembly.
	always_comb begin
		out_push = 1'b0;
		out_word = '{event_kind: srts_pkg::EV_DISPATCH,
			process_index: best_idx_ext[3:0], event_time: sim_time_q,
			turnaround: '0, waiting: '0, total_waiting: sum_w_q,
			total_turnaround: sum_t_q, last_result: 1'b0};
		if (state_q == ST_DISP) begin
			out_push = changed && out_free;
		end else if (state_q == ST_EMITC) begin
			out_push = out_free;
			out_word.event_kind  = srts_pkg::EV_COMPLETE;
			out_word.turnaround  = tat_q;
			out_word.waiting     = wt_q;
			out_word.last_result = (done_q == count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			count_q     <= '0;
			done_q      <= '0;
			sim_time_q  <= '0;
			run_vld_q   <= 1'b0;
			run_idx_q   <= '0;
			sum_w_q     <= '0;
			sum_t_q     <= '0;
			ptr_q       <= '0;
			rd_vld_s1   <= 1'b0;
			rd_last_s1  <= 1'b0;
			found_q     <= 1'b0;
			nxt_found_q <= 1'b0;
		end else begin
			rd_vld_s1  <= rd_en;
			rd_last_s1 <= (ptr_q == count_q - CNT_W'(1));
			unique case (state_q)
				ST_LOAD: begin
					if (load.valid) begin
						if (count_q < CNT_W'(MAX_PROCS)) begin
							count_q <= count_q + CNT_W'(1);
						end
						if (load.last_process) begin
							sim_time_q  <= '0;
							run_vld_q   <= 1'b0;
							done_q      <= '0;
							sum_w_q     <= '0;
							sum_t_q     <= '0;
							ptr_q       <= '0;
							found_q     <= 1'b0;
							nxt_found_q <= 1'b0;
							state_q     <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						ptr_q <= ptr_q + CNT_W'(1);
					end
					if (rd_vld_s1) begin
						if (is_ready && is_better) begin
							found_q <= 1'b1;
						end
						if (is_future && (!nxt_found_q || mem_rd_s1.arrival < nxt_arr_q)) begin
							nxt_found_q <= 1'b1;
						end
						if (rd_last_s1) begin
							state_q <= ST_DECIDE;
						end
					end
				end
				ST_DECIDE: begin
					if (!found_q) begin
						// Nothing ready: jump to the next arrival.
						sim_time_q  <= TW'(nxt_arr_q);
						ptr_q       <= '0;
						nxt_found_q <= 1'b0;
						state_q     <= ST_SCAN;
					end else begin
						state_q <= ST_DISP;
					end
				end
				ST_DISP: begin
					if (!changed) begin
						state_q <= ST_RUN;
					end else if (out_free) begin
						run_vld_q <= 1'b1;
						run_idx_q <= best_idx_q;
						state_q   <= ST_RUN;
					end
				end
				ST_RUN: begin
					sim_time_q <= sim_time_q + TW'(len_q);
					if (rem_left == '0) begin
						state_q <= ST_TAT;
					end else begin
						ptr_q       <= '0;
						found_q     <= 1'b0;
						nxt_found_q <= 1'b0;
						state_q     <= ST_SCAN;
					end
				end
				ST_TAT: begin
					state_q <= ST_SUMS;
				end
				ST_SUMS: begin
					sum_t_q <= sum_t_q + SW'(tat_q);
					sum_w_q <= sum_w_q + SW'(tat_q - TW'(best_burst_q));
					done_q  <= done_q + CNT_W'(1);
					state_q <= ST_EMITC;
				end
				ST_EMITC: begin
					if (out_free) begin
						ptr_q       <= '0;
						found_q     <= 1'b0;
						nxt_found_q <= 1'b0;
						if (done_q == count_q) begin
							count_q    <= '0;
							done_q     <= '0;
							sim_time_q <= '0;
							run_vld_q  <= 1'b0;
							sum_w_q    <= '0;
							sum_t_q    <= '0;
							state_q    <= ST_LOAD;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// Payload registers of the scan and of the completion arithmetic.
	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN && rd_vld_s1) begin
			if (is_ready && is_better) begin
				best_idx_q   <= rd_idx_s1;
				best_rem_q   <= mem_rd_s1.remaining;
				best_arr_q   <= mem_rd_s1.arrival;
				best_burst_q <= mem_rd_s1.burst;
			end
			if (is_future && (!nxt_found_q || mem_rd_s1.arrival < nxt_arr_q)) begin
				nxt_arr_q <= mem_rd_s1.arrival;
			end
		end
		if (rd_en) begin
			rd_idx_s1 <= ptr_q[ADDR_W-1:0];
		end
		if (state_q == ST_DECIDE) begin
			// Run to completion, or only until the next arrival can preempt.
			if (nxt_found_q && (gap < TW'(best_rem_q))) begin
				len_q <= gap[BW-1:0];
			end else begin
				len_q <= best_rem_q;
			end
		end
		if (state_q == ST_TAT) begin
			tat_q <= sim_time_q - TW'(best_arr_q);
		end
		if (state_q == ST_SUMS) begin
			wt_q <= tat_q - TW'(best_burst_q);
		end
	end

	srts_out_reg u_out_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.word   (out_word),
		.free   (out_free),
		.report (report)
	);

endmodule
